// ===== src/dds_pkg.sv =====
package dds_pkg;

    localparam int DDS_DIGITS = 10;
    localparam int DDS_WIDTH  = 31;

    // Ten decimal digit values need four bits.
    typedef logic [3:0] t_digit;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SPLIT,
        ST_BUILD,
        ST_DONE
    } t_back_state;

    // Shared status between front queue and back part.
    typedef struct packed {
        logic empty;
        logic full;
    } t_queue_status;

endpackage

// ===== src/dds_if.sv =====
interface dds_if #(
    parameter int W = 31
) ();
    logic         valid;
    logic         ready;
    logic [W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== src/decimal_digit_sorter_unit.sv =====
// The unit pops an accepted item from its queue, splits it into DIGITS
// decimal digits, rebuilds them in ascending order, and holds the result
// until it is taken. The back part works on one item at a time; a
// two-entry queue takes new items meanwhile. Reset: synchronous, active
// low; clears queue and back state machine.
module decimal_digit_sorter_unit #(
    parameter int DIGITS = dds_pkg::DDS_DIGITS,
    parameter int WIDTH  = dds_pkg::DDS_WIDTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    dds_if.sink   s_value,
    dds_if.source m_sorted_value
);
    import dds_pkg::*;

    // The front part buffers accepted items; the back part splits each into
    // decimal digits, counts them, and rebuilds the ascending number.
    logic [WIDTH-1:0] w_value;
    logic             w_pop;
    t_queue_status    w_status;

    dds_front #(.WIDTH(WIDTH)) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_in     (s_value),
        .i_pop    (w_pop),
        .o_value  (w_value),
        .o_status (w_status)
    );

    dds_back #(.DIGITS(DIGITS), .WIDTH(WIDTH)) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_value  (w_value),
        .i_status (w_status),
        .o_pop    (w_pop),
        .m_out    (m_sorted_value)
    );
endmodule

// ===== src/dds_front.sv =====
module dds_front #(
    parameter int WIDTH = 31
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    dds_if.sink              s_in,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_value,
    output dds_pkg::t_queue_status o_status
);
    import dds_pkg::*;

    // Two-entry queue of accepted items.
    logic [WIDTH-1:0] r_mem [2];
    logic             r_wr_ptr;
    logic             r_rd_ptr;
    logic [1:0]       r_count;
    logic             w_push;

    assign o_status.empty = (r_count == 2'd0);
    assign o_status.full  = (r_count == 2'd2);
    assign s_in.ready     = !o_status.full;
    assign w_push         = s_in.valid && s_in.ready;
    assign o_value        = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= s_in.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            unique case ({w_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end
endmodule

// ===== src/dds_back.sv =====
module dds_back #(
    parameter int DIGITS = 10,
    parameter int WIDTH  = 31
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [WIDTH-1:0] i_value,
    input  dds_pkg::t_queue_status i_status,
    output logic             o_pop,
    dds_if.source            m_out
);
    import dds_pkg::*;

    localparam int CW = $clog2(DIGITS + 1);
    // Scaled reciprocal of ten; exact quotient for any value below 2**32.
    localparam logic [31:0] RECIP10 = 32'hCCCC_CCCD;

    t_back_state r_state, n_state;
    logic [WIDTH-1:0]   r_work;
    logic [WIDTH-1:0]   r_acc;
    logic [CW-1:0]      r_step;
    logic [CW-1:0]      r_cnt [10];
    t_digit             r_dig;
    logic [WIDTH-1:0]   r_result;

    logic [63:0]        w_mul;
    logic [WIDTH-1:0]   w_quot;
    logic [WIDTH-1:0]   w_tenq;
    logic [3:0]         w_rem;
    logic [WIDTH-1:0]   w_prod;

    // Divide by ten through the reciprocal, one digit per cycle.
    assign w_mul  = 64'(32'(r_work)) * 64'(RECIP10);
    assign w_quot = WIDTH'(w_mul[63:35]);
    assign w_tenq = (w_quot << 3) + (w_quot << 1);
    assign w_rem  = 4'(r_work - w_tenq);
    assign w_prod = (r_acc << 3) + (r_acc << 1) + WIDTH'(r_dig);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (!i_status.empty) n_state = ST_SPLIT;
            ST_SPLIT: if (r_step == CW'(DIGITS - 1)) n_state = ST_BUILD;
            ST_BUILD: if (r_dig == 4'd9 && r_cnt[9] == '0) n_state = ST_DONE;
            ST_DONE:  if (m_out.ready) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_pop       = (r_state == ST_IDLE) && !i_status.empty;
        m_out.valid = (r_state == ST_DONE);
        m_out.data  = r_result;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                r_work <= i_value;
                r_step <= '0;
                r_acc  <= '0;
                r_dig  <= 4'd1;
                for (int k = 0; k < 10; k++) r_cnt[k] <= '0;
            end
            ST_SPLIT: begin
                r_cnt[w_rem] <= r_cnt[w_rem] + CW'(1);
                r_work       <= w_quot;
                r_step       <= r_step + CW'(1);
            end
            ST_BUILD: begin
                // Emit digits lowest nonzero value first, skipping zeros.
                if (r_cnt[r_dig] != '0) begin
                    r_acc          <= w_prod;
                    r_cnt[r_dig]   <= r_cnt[r_dig] - CW'(1);
                    r_result       <= w_prod;
                end else begin
                    r_result <= r_acc;
                    if (r_dig != 4'd9) begin
                        r_dig <= r_dig + 4'd1;
                    end
                end
            end
            default: begin
            end
        endcase
    end
endmodule

// ===== src/dds_checker.sv =====
module dds_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [30:0] i_out_data
);
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_data))
        else $error("result changed while stalled");
    a_ready_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> i_in_ready)
        else $error("input not ready after reset");
    a_no_out_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result shown after reset");
    a_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_ready |=> !i_out_valid)
        else $error("results too close");
    a_ready_keep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_ready && !i_in_valid |=> i_in_ready)
        else $error("input ready dropped without an item");
endmodule

bind decimal_digit_sorter_unit dds_checker u_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (s_value.valid),
    .i_in_ready  (s_value.ready),
    .i_out_valid (m_sorted_value.valid),
    .i_out_ready (m_sorted_value.ready),
    .i_out_data  (m_sorted_value.data)
);
